>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pno_pkg.sv
// Shared constants, types and table functions for the gradient noise block.
package pno_pkg;

  localparam int OCTAVES    = 3;
  localparam int ANGLE_BITS = 10;
  localparam int COORD_BITS = 16;

  localparam int POS_W    = 16;
  localparam int SIZE_W   = 17;
  localparam int DIV_W    = 16;
  localparam int SCALE_W  = 16;
  localparam int HEIGHT_W = 25;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;

  localparam int UW     = POS_W + COORD_BITS;
  localparam int CELL_W = 32;
  localparam int PW     = COORD_BITS + CELL_W;
  localparam int OCT_W  = $clog2(OCTAVES + 1);
  localparam int DW     = COORD_BITS + 5;
  localparam int QTR    = 1 << (ANGLE_BITS - 2);

  localparam int FIFO_DEPTH = 4;
  localparam int OCT_LAT    = 11;
  localparam int BACK_LAT   = OCT_LAT + 6;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 2'd2;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = 17'd512;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;

  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  typedef struct packed {
    logic [UW-1:0] v;
    logic [UW-1:0] u;
  } coord_t;

  typedef logic [14:0] qtab_t [0:QTR];

  function automatic logic [31:0] rot16(input logic [31:0] a);
    return {a[15:0], a[31:16]};
  endfunction

  // Shift-subtract quotient, used only while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rm;
    q = '0;
    rm = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = {rm[63:0], a[b]};
      if (rm >= {1'b0, d}) begin
        rm = rm - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter sine wave in Q14 from a Q30 Taylor series up to x^13.
  function automatic qtab_t build_qsin();
    qtab_t t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] trm;
    logic [63:0] r;
    logic [63:0] dv;
    logic signed [63:0] acc;
    int j;
    int n;
    for (j = 0; j <= QTR; j++) begin
      x = (PI_Q30 * 64'(j)) >> (ANGLE_BITS - 1);
      x2 = (x * x) >> 30;
      trm = x;
      acc = signed'(x);
      for (n = 1; n <= 6; n++) begin
        dv = 64'((2 * n) * (2 * n + 1));
        trm = udiv64((trm * x2) >> 30, dv);
        if (n[0]) acc = acc - signed'(trm);
        else acc = acc + signed'(trm);
      end
      if (acc < 0) acc = 0;
      r = (64'(acc) + 64'd32768) >> 16;
      if (r > 64'd16384) r = 64'd16384;
      t[j] = r[14:0];
    end
    return t;
  endfunction

  localparam qtab_t QSIN = build_qsin();

  // Full-wave Q1.14 sine built from the quarter table.
  function automatic logic signed [15:0] sine_at(input logic [ANGLE_BITS-1:0] k);
    logic [1:0] quad;
    logic [ANGLE_BITS-2:0] idx;
    logic signed [15:0] mag;
    quad = k[ANGLE_BITS-1 -: 2];
    idx = {1'b0, k[ANGLE_BITS-3:0]};
    if (quad[0]) idx = (ANGLE_BITS-1)'(QTR) - idx;
    mag = signed'({1'b0, QSIN[idx]});
    return quad[1] ? -mag : mag;
  endfunction

endpackage

>>> src/pno_front.sv
// Front end: input capture and pipelined restoring dividers for coordinate normalization.
module pno_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pno_pkg::POS_W-1:0]        x_pos,
  input  logic [pno_pkg::POS_W-1:0]        y_pos,
  input  logic [pno_pkg::SIZE_W-1:0]       size_x,
  input  logic [pno_pkg::SIZE_W-1:0]       size_y,
  input  logic                             q_full,
  output logic                             push,
  output pno_pkg::coord_t                  coord
);

  localparam int STEPS = pno_pkg::UW;
  localparam int F     = pno_pkg::COORD_BITS;
  localparam int DVW   = pno_pkg::DIV_W;
  localparam int SW    = pno_pkg::SIZE_W;

  logic [STEPS:0]               vld;
  logic                         en;
  logic [DVW-1:0]               dvsr     [2];
  logic [DVW-1:0]               rem      [2][STEPS+1];
  logic [STEPS-1:0]             quo      [2][STEPS+1];
  logic [pno_pkg::POS_W-1:0]    num      [2][STEPS];
  logic [DVW-1:0]               rem_next [2][STEPS];
  logic [STEPS-1:0]             quo_next [2][STEPS];

  // size of 0 or 1 divides by one
  always_comb begin
    dvsr[0] = (size_x < SW'(2)) ? DVW'(1) : DVW'(size_x - SW'(1));
    dvsr[1] = (size_y < SW'(2)) ? DVW'(1) : DVW'(size_y - SW'(1));
  end

  // one quotient bit per stage, MSB first
  always_comb begin
    logic [STEPS-1:0] dvd;
    logic [DVW:0]     part;
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < STEPS; j++) begin
        dvd = {num[l][j], {F{1'b0}}};
        part = {rem[l][j], dvd[STEPS-1-j]};
        quo_next[l][j] = quo[l][j];
        if (part >= {1'b0, dvsr[l]}) begin
          rem_next[l][j] = DVW'(part - {1'b0, dvsr[l]});
          quo_next[l][j][STEPS-1-j] = 1'b1;
        end else begin
          rem_next[l][j] = part[DVW-1:0];
        end
      end
    end
  end

  assign en       = !(vld[STEPS] && q_full);
  assign s_tready = en;
  assign push     = vld[STEPS] && !q_full;
  assign coord.u  = quo[0][STEPS];
  assign coord.v  = quo[1][STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0][0] <= x_pos;
      num[1][0] <= y_pos;
      for (int l = 0; l < 2; l++) begin
        rem[l][0] <= '0;
        quo[l][0] <= '0;
        for (int j = 0; j < STEPS; j++) begin
          rem[l][j+1] <= rem_next[l][j];
          quo[l][j+1] <= quo_next[l][j];
        end
        for (int j = 0; j < STEPS - 1; j++) begin
          num[l][j+1] <= num[l][j];
        end
      end
    end
  end

endmodule

>>> src/pno_fifo.sv
// Small coordinate queue between the front end and the noise pipeline.
module pno_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pno_pkg::coord_t din,
  output logic            full,
  input  logic            pop,
  output pno_pkg::coord_t dout,
  output logic            valid
);

  localparam int DEPTH = pno_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  pno_pkg::coord_t mem [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + AW'(1);
      if (pop) rptr <= rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

endmodule

>>> src/pno_octave.sv
// One noise octave: corner hashing, gradient lookup, dot products and smoothstep blend.
module pno_octave (
  input  logic                              clk,
  input  logic                              en,
  input  logic [pno_pkg::OCT_W-1:0]         oct_shift,
  input  pno_pkg::coord_t                   coord,
  output logic signed [pno_pkg::DW-1:0]     term
);

  localparam int F  = pno_pkg::COORD_BITS;
  localparam int A  = pno_pkg::ANGLE_BITS;
  localparam int PW = pno_pkg::PW;
  localparam int DW = pno_pkg::DW;
  localparam logic signed [F+1:0] ONE_D = (F+2)'(1 << F);
  localparam logic signed [DW+1:0] ONE_N = (DW+2)'(1 << F);

  logic [PW-1:0] px;
  logic [PW-1:0] py;

  // corner c: bit 0 picks cx+1, bit 1 picks cy+1
  logic [31:0]  cx0, cx1, cy0, cy1;
  logic [F-1:0] wx1, wy1;
  logic [31:0]  ax0, ax1, cy0_2, cy1_2;
  logic [F-1:0] wx2, wy2;
  logic [2*F-1:0] wwx, wwy;
  logic [31:0]  b3 [4];
  logic [31:0]  a3 [4];
  logic [F-1:0] wx3, wy3, w2x3, w2y3;
  logic [2*F-1:0] w3x3, w3y3;
  logic [31:0]  h4 [4];
  logic [F-1:0] wx4, wy4;
  logic signed [F+1:0] sx4, sy4;
  logic signed [15:0] gx5 [4];
  logic signed [15:0] gy5 [4];
  logic [F-1:0] wx5, wy5;
  logic signed [F+1:0] sx5, sy5;
  logic signed [F+17:0] pxp6 [4];
  logic signed [F+17:0] pyp6 [4];
  logic signed [F+1:0] sx6, sy6;
  logic signed [DW-1:0] dot7 [4];
  logic signed [F+1:0] sx7, sy7;
  logic signed [DW+F+2:0] mt8, mb8;
  logic signed [DW-1:0] d00_8, d01_8;
  logic signed [F+1:0] sy8;
  logic signed [DW-1:0] top9, bot9;
  logic signed [F+1:0] sy9;
  logic signed [DW+F+2:0] my10;
  logic signed [DW-1:0] top10;

  assign px = PW'(coord.u) << oct_shift;
  assign py = PW'(coord.v) << oct_shift;

  always_ff @(posedge clk) begin
    logic [A-1:0] k;
    logic signed [F+1:0] dxc;
    logic signed [F+1:0] dyc;
    logic signed [F+18:0] dsum;
    logic signed [DW:0] dtb;
    logic signed [DW+1:0] nsum;
    if (en) begin
      // cell and fraction
      cx0 <= px[F +: 32];
      cx1 <= px[F +: 32] + 32'd1;
      cy0 <= py[F +: 32];
      cy1 <= py[F +: 32] + 32'd1;
      wx1 <= px[F-1:0];
      wy1 <= py[F-1:0];
      // hash step one, w squared
      ax0 <= 32'(cx0 * pno_pkg::HASH_M1);
      ax1 <= 32'(cx1 * pno_pkg::HASH_M1);
      cy0_2 <= cy0;
      cy1_2 <= cy1;
      wx2 <= wx1;
      wy2 <= wy1;
      wwx <= wx1 * wx1;
      wwy <= wy1 * wy1;
      // hash step two, w cubed
      for (int c = 0; c < 4; c++) begin
        a3[c] <= c[0] ? ax1 : ax0;
        b3[c] <= 32'(((c[1] ? cy1_2 : cy0_2) ^ pno_pkg::rot16(c[0] ? ax1 : ax0))
                      * pno_pkg::HASH_M2);
      end
      wx3 <= wx2;
      wy3 <= wy2;
      w2x3 <= wwx[2*F-1:F];
      w2y3 <= wwy[2*F-1:F];
      w3x3 <= wwx[2*F-1:F] * wx2;
      w3y3 <= wwy[2*F-1:F] * wy2;
      // hash step three, smoothstep
      for (int c = 0; c < 4; c++) begin
        h4[c] <= 32'((a3[c] ^ pno_pkg::rot16(b3[c])) * pno_pkg::HASH_M3);
      end
      wx4 <= wx3;
      wy4 <= wy3;
      sx4 <= signed'((F+2)'(3) * (F+2)'(w2x3) - (F+2)'(2) * (F+2)'(w3x3[2*F-1:F]));
      sy4 <= signed'((F+2)'(3) * (F+2)'(w2y3) - (F+2)'(2) * (F+2)'(w3y3[2*F-1:F]));
      // gradient lookup
      for (int c = 0; c < 4; c++) begin
        k = h4[c][31 -: A];
        gx5[c] <= pno_pkg::sine_at(k);
        gy5[c] <= pno_pkg::sine_at(k + A'(pno_pkg::QTR));
      end
      wx5 <= wx4;
      wy5 <= wy4;
      sx5 <= sx4;
      sy5 <= sy4;
      // offset times gradient
      for (int c = 0; c < 4; c++) begin
        dxc = signed'({2'b00, wx5}) - (c[0] ? ONE_D : '0);
        dyc = signed'({2'b00, wy5}) - (c[1] ? ONE_D : '0);
        pxp6[c] <= dxc * gx5[c];
        pyp6[c] <= dyc * gy5[c];
      end
      sx6 <= sx5;
      sy6 <= sy5;
      // dot products, floor by 2^14
      for (int c = 0; c < 4; c++) begin
        dsum = (F+19)'(pxp6[c]) + (F+19)'(pyp6[c]);
        dot7[c] <= DW'(dsum >>> 14);
      end
      sx7 <= sx6;
      sy7 <= sy6;
      // x blend
      mt8 <= ((DW+1)'(dot7[1]) - (DW+1)'(dot7[0])) * sx7;
      mb8 <= ((DW+1)'(dot7[3]) - (DW+1)'(dot7[2])) * sx7;
      d00_8 <= dot7[0];
      d01_8 <= dot7[2];
      sy8 <= sy7;
      top9 <= d00_8 + DW'(mt8 >>> F);
      bot9 <= d01_8 + DW'(mb8 >>> F);
      sy9 <= sy8;
      // y blend
      dtb = (DW+1)'(bot9) - (DW+1)'(top9);
      my10 <= dtb * sy9;
      top10 <= top9;
      // remap to (n+1)/2
      nsum = (DW+2)'(top10) + (DW+2)'(my10 >>> F) + ONE_N;
      term <= DW'(nsum >>> 1);
    end
  end

endmodule

>>> src/pno_back.sv
// Back end: octave pipelines, weighting, gain, normalization and output register.
module pno_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  pno_pkg::coord_t                    q_coord,
  output logic                               q_pop,
  input  logic [pno_pkg::SCALE_W-1:0]        noise_scale,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pno_pkg::HEIGHT_W-1:0]       height
);

  localparam int O    = pno_pkg::OCTAVES;
  localparam int F    = pno_pkg::COORD_BITS;
  localparam int DW   = pno_pkg::DW;
  localparam int LAT  = pno_pkg::BACK_LAT;
  localparam int XB   = DW + 3;
  localparam int KI   = XB + 3;
  localparam int SW   = XB + 1;
  localparam int PRW  = SW - 1 + pno_pkg::SCALE_W;
  localparam int XFW  = PRW + O;
  localparam int HW   = pno_pkg::HEIGHT_W;
  localparam int XB2  = HW + O;
  localparam int K2   = XB2 + O;
  localparam int DEN  = (1 << O) - 1;
  localparam logic [K2:0] MD = (K2+1)'(((64'd1 << K2) + 64'(DEN) - 64'd1) / 64'(DEN));
  localparam logic [XFW-1:0] SAT_LIM = XFW'(DEN) << HW;
  localparam logic signed [SW-1:0] HALF = SW'(1 << (DW - 1));

  logic [LAT:1]           vld;
  logic                   en;
  logic signed [DW-1:0]   term [O];
  logic [XB+KI:0]         rq   [O];
  logic signed [SW-1:0]   sum_c;
  logic signed [SW-1:0]   sum13;
  logic [PRW-1:0]         prod14;
  logic [XFW-1:0]         xf;
  logic [XB2-1:0]         x15;
  logic                   sat15;
  logic [XB2+K2:0]        rp16;
  logic                   sat16;

  assign en       = !vld[LAT] || m_tready;
  assign q_pop    = en && q_valid;
  assign m_tvalid = vld[LAT];

  for (genvar o = 0; o < O; o++) begin : g_oct
    localparam int DIVI = O - o;
    localparam logic [KI:0] MI = (KI+1)'(((64'd1 << KI) + 64'(DIVI) - 64'd1) / 64'(DIVI));
    localparam logic [XB-1:0] OFF = XB'(DIVI) << (DW - 1);

    pno_octave u_oct (
      .clk       (clk),
      .en        (en),
      .oct_shift (pno_pkg::OCT_W'(DIVI)),
      .coord     (q_coord),
      .term      (term[o])
    );

    // floor(term / DIVI) via offset and reciprocal
    always_ff @(posedge clk) begin
      if (en) rq[o] <= XB'(XB'(term[o]) + OFF) * MI;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int o = 0; o < O; o++) begin
      sum_c = sum_c + signed'({1'b0, rq[o][KI +: XB]}) - HALF;
    end
  end

  assign xf = (XFW'(prod14) << (O - 1)) >> (F - 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum13  <= sum_c;
      prod14 <= (sum13 > 0 ? sum13[SW-2:0] : '0) * noise_scale;
      sat15  <= (xf >= SAT_LIM);
      x15    <= xf[XB2-1:0];
      rp16   <= x15 * MD;
      sat16  <= sat15;
      height <= sat16 ? pno_pkg::HEIGHT_MAX : HW'(rp16 >> K2);
    end
  end

endmodule

>>> src/perlin_noise_octaves_top.sv
// Top level of the three-octave gradient noise height generator.
// Throughput: one request per cycle unless back-pressure on m_tready fills the queue
// and stalls the divider pipeline; a 32-stage divider pipeline feeds a 4-entry
// queue, and a 17-stage octave and gain pipeline drains it into the output register.
// Reset (rst, synchronous) empties both pipelines and the queue and loads
// size_x = size_y = 512 and noise_scale = 256; there is no clearing pass.
module perlin_noise_octaves_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pno_pkg::IN_TDATA_W-1:0]      s_tdata,   // [15:0] x_pos, [31:16] y_pos
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pno_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [24:0] height, [31:25] zero
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pno_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pno_pkg::SIZE_W-1:0]          cfg_data
);

  logic [pno_pkg::SIZE_W-1:0]   size_x;
  logic [pno_pkg::SIZE_W-1:0]   size_y;
  logic [pno_pkg::SCALE_W-1:0]  noise_scale;
  logic                         push;
  logic                         q_full;
  logic                         q_valid;
  logic                         q_pop;
  pno_pkg::coord_t              f_coord;
  pno_pkg::coord_t              q_coord;
  logic [pno_pkg::HEIGHT_W-1:0] height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= pno_pkg::SIZE_RST;
      size_y      <= pno_pkg::SIZE_RST;
      noise_scale <= pno_pkg::SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pno_pkg::REG_SIZE_X:      size_x <= cfg_data;
        pno_pkg::REG_SIZE_Y:      size_y <= cfg_data;
        pno_pkg::REG_NOISE_SCALE: noise_scale <= cfg_data[pno_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  pno_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .x_pos    (s_tdata[15:0]),
    .y_pos    (s_tdata[31:16]),
    .size_x   (size_x),
    .size_y   (size_y),
    .q_full   (q_full),
    .push     (push),
    .coord    (f_coord)
  );

  pno_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_coord),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_coord),
    .valid (q_valid)
  );

  pno_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_coord     (q_coord),
    .q_pop       (q_pop),
    .noise_scale (noise_scale),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .height      (height)
  );

  assign m_tdata = {(pno_pkg::OUT_TDATA_W - pno_pkg::HEIGHT_W)'(0), height};

endmodule

>>> src/pno_checker.sv
// Port-level checker for the noise top level, bound to it.
`include "assert_macros.svh"

module pno_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [16:0] cfg_data
);

  `CHK_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
  `CHK_ASSERT(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")
  `CHK_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[31:25] == 7'd0, "height padding set")
  `CHK_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result right after reset")

endmodule

bind perlin_noise_octaves_top pno_checker u_pno_checker (.*);
